// ----- rtl/core/swqt_pkg.sv -----
// ----------------------------------------------------------------------------
// swqt_pkg
// Shared types and codes for the semaphore wait queue table.
// ----------------------------------------------------------------------------
package swqt_pkg;

    localparam int KEY_BITS  = 32;
    localparam int PROC_BITS = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_HEAD   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_OUT    = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_FREE  = 2'd1;
    localparam logic [1:0] STS_NOTFOUND = 2'd2;
    localparam logic [1:0] STS_BLOCKED  = 2'd3;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [KEY_BITS-1:0]  sem_key;
        logic [PROC_BITS-1:0] proc_id;
    } t_in;

    typedef struct packed {
        logic [1:0]           status;
        logic [PROC_BITS-1:0] result_proc;
    } t_out;

    // directory update request
    typedef struct packed {
        logic set;
        logic clr;
    } t_dir_op;

    // directory lookup result
    typedef struct packed {
        logic match;
        logic free;
    } t_dir_hit;

endpackage

// ----- rtl/core/swqt_sem_dir.sv -----
// ----------------------------------------------------------------------------
// swqt_sem_dir
// Descriptor directory: busy flags, keys, parallel key match and lowest
// free descriptor search.
// ----------------------------------------------------------------------------
module swqt_sem_dir
    import swqt_pkg::*;
#(
    parameter int NUM_SEMS  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dir_op              i_op,
    input  logic [$clog2(NUM_SEMS > 1 ? NUM_SEMS : 2)-1:0] i_slot,
    input  logic [(KEY_WIDTH < KEY_BITS ? KEY_WIDTH : KEY_BITS)-1:0] i_key,
    output t_dir_hit             o_hit,
    output logic [$clog2(NUM_SEMS > 1 ? NUM_SEMS : 2)-1:0] o_match_idx,
    output logic [$clog2(NUM_SEMS > 1 ? NUM_SEMS : 2)-1:0] o_free_idx
);

    localparam int SW = $clog2(NUM_SEMS > 1 ? NUM_SEMS : 2);
    localparam int KW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;

    logic [NUM_SEMS-1:0] r_busy;
    logic [NUM_SEMS-1:0] n_busy;
    logic [KW-1:0]       r_keys [NUM_SEMS];
    logic [NUM_SEMS-1:0] w_match;

    always_comb begin
        n_busy = r_busy;
        if (i_op.set) begin
            n_busy[i_slot] = 1'b1;
        end else if (i_op.clr) begin
            n_busy[i_slot] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.set) begin
            r_keys[i_slot] <= i_key;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SEMS; i++) begin
            w_match[i] = r_busy[i] && (r_keys[i] == i_key);
        end
    end

    always_comb begin
        o_match_idx = '0;
        o_free_idx  = '0;
        for (int i = NUM_SEMS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_match_idx = SW'(i);
            end
            if (!r_busy[i]) begin
                o_free_idx = SW'(i);
            end
        end
        o_hit.match = |w_match;
        o_hit.free  = ~&r_busy;
    end

`ifndef SYNTHESIS
    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("two busy descriptors hold the same key");
`endif

endmodule

// ----- rtl/core/swqt_ctrl.sv -----
// ----------------------------------------------------------------------------
// swqt_ctrl
// Command sequencer with the head/tail memory and the process link memory.
// ----------------------------------------------------------------------------
module swqt_ctrl
    import swqt_pkg::*;
#(
    parameter int NUM_SEMS  = 32,
    parameter int NUM_PROCS = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in      i_in_data,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_out     o_res_data,
    output t_dir_op  o_dir_op,
    output logic [$clog2(NUM_SEMS > 1 ? NUM_SEMS : 2)-1:0] o_dir_slot,
    output logic [(KEY_WIDTH < KEY_BITS ? KEY_WIDTH : KEY_BITS)-1:0] o_dir_key,
    input  t_dir_hit i_dir_hit,
    input  logic [$clog2(NUM_SEMS > 1 ? NUM_SEMS : 2)-1:0] i_match_idx,
    input  logic [$clog2(NUM_SEMS > 1 ? NUM_SEMS : 2)-1:0] i_free_idx
);

    localparam int SW  = $clog2(NUM_SEMS > 1 ? NUM_SEMS : 2);
    localparam int KW  = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int NP  = (NUM_PROCS < (1 << PROC_BITS)) ? NUM_PROCS : (1 << PROC_BITS);
    localparam int PIW = $clog2(NP > 1 ? NP : 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_PRC  = 3'd2;
    localparam logic [2:0] S_SEM  = 3'd3;
    localparam logic [2:0] S_UNL  = 3'd4;
    localparam logic [2:0] S_PW   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    typedef struct packed {
        logic           nil;
        logic [PIW-1:0] idx;
    } t_link;

    typedef struct packed {
        t_link head;
        t_link tail;
    } t_sem_ent;

    typedef struct packed {
        logic [SW-1:0] slot;
        t_link         nxt;
        t_link         prv;
    } t_proc_ent;

    localparam t_link NIL = '{nil: 1'b1, idx: '0};

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_cmd, n_cmd;
    logic [KW-1:0]        r_key, n_key;
    logic [PROC_BITS-1:0] r_pid, n_pid;
    logic [SW-1:0]        r_slot, n_slot;
    logic                 r_new, n_new;
    t_sem_ent             r_sem, n_sem;
    logic [PIW-1:0]       r_p, n_p;
    t_link                r_prv, n_prv;
    t_link                r_nxt, n_nxt;
    logic [PIW-1:0]       r_pa_addr, n_pa_addr;
    logic                 r_pa_next, n_pa_next;
    t_link                r_pa_val, n_pa_val;
    logic                 r_pa_more, n_pa_more;
    logic [1:0]           r_status, n_status;
    logic [PIW-1:0]       r_res, n_res;
    logic [NP-1:0]        r_blocked, n_blocked;

    t_sem_ent  r_sem_mem [NUM_SEMS];
    t_sem_ent  r_sem_rd;
    logic      sem_we;
    logic [SW-1:0] sem_waddr, sem_raddr;
    t_sem_ent  sem_wdata;

    t_proc_ent r_prc_mem [NP];
    t_proc_ent r_prc_rd;
    logic      prc_we;
    logic [PIW-1:0] prc_waddr, prc_raddr;
    t_proc_ent prc_wdata;

    logic           in_fire;
    logic           pid_ok;
    logic [PIW-1:0] pidx;
    t_link          pid_link;
    t_link          ins_tail;
    t_link          unl_head;
    t_link          unl_tail;

    assign in_fire  = i_in_valid && o_in_ready;
    assign pid_ok   = int'(r_pid) < NP;
    assign pidx     = r_pid[PIW-1:0];
    assign pid_link = '{nil: 1'b0, idx: pidx};
    assign ins_tail = r_new ? NIL : r_sem_rd.tail;
    assign unl_head = r_prv.nil ? r_nxt : r_sem.head;
    assign unl_tail = r_nxt.nil ? r_prv : r_sem.tail;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_pid     = r_pid;
        n_slot    = r_slot;
        n_new     = r_new;
        n_sem     = r_sem;
        n_p       = r_p;
        n_prv     = r_prv;
        n_nxt     = r_nxt;
        n_pa_addr = r_pa_addr;
        n_pa_next = r_pa_next;
        n_pa_val  = r_pa_val;
        n_pa_more = r_pa_more;
        n_status  = r_status;
        n_res     = r_res;
        n_blocked = r_blocked;
        sem_we    = 1'b0;
        sem_waddr = r_slot;
        sem_raddr = r_slot;
        sem_wdata = r_sem_rd;
        prc_we    = 1'b0;
        prc_waddr = r_pa_addr;
        prc_raddr = r_pa_addr;
        prc_wdata = r_prc_rd;
        o_dir_op  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd   = i_in_data.cmd;
                    n_key   = i_in_data.sem_key[KW-1:0];
                    n_pid   = i_in_data.proc_id;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_status = STS_OK;
                n_res    = '0;
                unique case (r_cmd) inside
                    CMD_INSERT: begin
                        if (!pid_ok) begin
                            n_status = STS_NOTFOUND;
                            n_state  = S_DONE;
                        end else if (r_blocked[pidx]) begin
                            n_status = STS_BLOCKED;
                            n_state  = S_DONE;
                        end else if (i_dir_hit.match) begin
                            n_slot    = i_match_idx;
                            n_new     = 1'b0;
                            sem_raddr = i_match_idx;
                            n_state   = S_SEM;
                        end else if (i_dir_hit.free) begin
                            n_slot    = i_free_idx;
                            n_new     = 1'b1;
                            sem_raddr = i_free_idx;
                            n_state   = S_SEM;
                        end else begin
                            n_status = STS_NO_FREE;
                            n_state  = S_DONE;
                        end
                    end
                    CMD_HEAD, CMD_REMOVE: begin
                        if (i_dir_hit.match) begin
                            n_slot    = i_match_idx;
                            sem_raddr = i_match_idx;
                            n_state   = S_SEM;
                        end else begin
                            n_status = STS_NOTFOUND;
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        if (!pid_ok || !r_blocked[pidx]) begin
                            n_status = STS_NOTFOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_p       = pidx;
                            prc_raddr = pidx;
                            n_state   = S_PRC;
                        end
                    end
                endcase
            end
            S_PRC: begin
                n_prv = r_prc_rd.prv;
                n_nxt = r_prc_rd.nxt;
                if (r_cmd == CMD_OUT) begin
                    n_slot    = r_prc_rd.slot;
                    sem_raddr = r_prc_rd.slot;
                    n_state   = S_SEM;
                end else begin
                    n_state = S_UNL;
                end
            end
            S_SEM: begin
                unique case (r_cmd) inside
                    CMD_INSERT: begin
                        sem_we         = 1'b1;
                        sem_wdata.head = ins_tail.nil ? pid_link : r_sem_rd.head;
                        sem_wdata.tail = pid_link;
                        o_dir_op.set   = r_new;
                        n_blocked[pidx] = 1'b1;
                        prc_we         = 1'b1;
                        prc_waddr      = pidx;
                        prc_wdata      = '{slot: r_slot, nxt: NIL, prv: ins_tail};
                        if (!ins_tail.nil) begin
                            prc_raddr = ins_tail.idx;
                            n_pa_addr = ins_tail.idx;
                            n_pa_next = 1'b1;
                            n_pa_val  = pid_link;
                            n_pa_more = 1'b0;
                            n_state   = S_PW;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_HEAD: begin
                        n_res   = r_sem_rd.head.idx;
                        n_state = S_DONE;
                    end
                    CMD_REMOVE: begin
                        n_sem     = r_sem_rd;
                        n_p       = r_sem_rd.head.idx;
                        prc_raddr = r_sem_rd.head.idx;
                        n_state   = S_PRC;
                    end
                    default: begin
                        n_sem   = r_sem_rd;
                        n_state = S_UNL;
                    end
                endcase
            end
            S_UNL: begin
                sem_we         = 1'b1;
                sem_wdata.head = unl_head;
                sem_wdata.tail = unl_tail;
                o_dir_op.clr   = unl_head.nil;
                n_blocked[r_p] = 1'b0;
                n_res          = r_p;
                if (!r_prv.nil) begin
                    prc_raddr = r_prv.idx;
                    n_pa_addr = r_prv.idx;
                    n_pa_next = 1'b1;
                    n_pa_val  = r_nxt;
                    n_pa_more = !r_nxt.nil;
                    n_state   = S_PW;
                end else if (!r_nxt.nil) begin
                    prc_raddr = r_nxt.idx;
                    n_pa_addr = r_nxt.idx;
                    n_pa_next = 1'b0;
                    n_pa_val  = r_prv;
                    n_pa_more = 1'b0;
                    n_state   = S_PW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PW: begin
                prc_we = 1'b1;
                if (r_pa_next) begin
                    prc_wdata.nxt = r_pa_val;
                end else begin
                    prc_wdata.prv = r_pa_val;
                end
                if (r_pa_more) begin
                    prc_raddr = r_nxt.idx;
                    n_pa_addr = r_nxt.idx;
                    n_pa_next = 1'b0;
                    n_pa_val  = r_prv;
                    n_pa_more = 1'b0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_blocked <= '0;
        end else begin
            r_state   <= n_state;
            r_blocked <= n_blocked;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_pid     <= n_pid;
        r_slot    <= n_slot;
        r_new     <= n_new;
        r_sem     <= n_sem;
        r_p       <= n_p;
        r_prv     <= n_prv;
        r_nxt     <= n_nxt;
        r_pa_addr <= n_pa_addr;
        r_pa_next <= n_pa_next;
        r_pa_val  <= n_pa_val;
        r_pa_more <= n_pa_more;
        r_status  <= n_status;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (sem_we) begin
            r_sem_mem[sem_waddr] <= sem_wdata;
        end
        r_sem_rd <= r_sem_mem[sem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (prc_we) begin
            r_prc_mem[prc_waddr] <= prc_wdata;
        end
        r_prc_rd <= r_prc_mem[prc_raddr];
    end

    assign o_in_ready             = (r_state == S_IDLE);
    assign o_res_valid            = (r_state == S_DONE);
    assign o_res_data.status      = r_status;
    assign o_res_data.result_proc = (r_status == STS_OK) ? PROC_BITS'(r_res) : '0;
    assign o_dir_slot             = r_slot;
    assign o_dir_key              = r_key;

`ifndef SYNTHESIS
    a_patch_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PW) |-> r_blocked[r_pa_addr])
        else $error("link patch on a process that is not blocked");

    a_insert_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_INSERT && r_status == STS_OK)
        |-> r_blocked[pidx])
        else $error("inserted process not marked blocked");

    a_out_unblocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_OUT && r_status == STS_OK)
        |-> !r_blocked[pidx])
        else $error("removed process still marked blocked");
`endif

endmodule

// ----- rtl/core/semaphore_wait_queue_table.sv -----
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table
// Pool of semaphore descriptors, each a key bound to a FIFO of blocked
// processes, with insert, head, remove-head and remove-given-process commands.
// ----------------------------------------------------------------------------
// One command is handled at a time and always yields one result transaction.
// A failed command goes from the lookup straight to its result; the other
// commands first walk a chain of dependent reads through the head/tail memory
// and the process link memory, each with one read and one write port and a
// registered read, and then write back the links where needed, while the key
// match runs across all descriptors in parallel. A new command is taken only
// after the result has left for the output register. A result may wait in the
// output register while the next command is accepted.
module semaphore_wait_queue_table
    import swqt_pkg::*;
#(
    parameter int NUM_SEMS  = 32,
    parameter int NUM_PROCS = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int SW = $clog2(NUM_SEMS > 1 ? NUM_SEMS : 2);
    localparam int KW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;

    t_dir_op       dir_op;
    t_dir_hit      dir_hit;
    logic [SW-1:0] dir_slot;
    logic [SW-1:0] match_idx;
    logic [SW-1:0] free_idx;
    logic [KW-1:0] dir_key;
    logic          res_valid;
    logic          res_ready;
    t_out          res_data;

    logic          r_out_valid;
    t_out          r_out_data;

    swqt_sem_dir #(
        .NUM_SEMS  (NUM_SEMS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dir (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dir_op),
        .i_slot      (dir_slot),
        .i_key       (dir_key),
        .o_hit       (dir_hit),
        .o_match_idx (match_idx),
        .o_free_idx  (free_idx)
    );

    swqt_ctrl #(
        .NUM_SEMS  (NUM_SEMS),
        .NUM_PROCS (NUM_PROCS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data),
        .o_dir_op    (dir_op),
        .o_dir_slot  (dir_slot),
        .o_dir_key   (dir_key),
        .i_dir_hit   (dir_hit),
        .i_match_idx (match_idx),
        .i_free_idx  (free_idx)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- tb/sv/tb_semaphore_wait_queue_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_semaphore_wait_queue_table
// Self-checking bench for the semaphore wait queue table. A short scripted
// sequence covers empty lookups, key extremes, double blocking, removal from
// the head, middle and tail of a queue and descriptor reuse. Random phases
// with varying input idling and output back-pressure follow. Every
// transaction is checked against the result in the script where one is given,
// else against a behavioural model of the descriptor pool and its process queues.
// ----------------------------------------------------------------------------
module tb_semaphore_wait_queue_table;
    import swqt_pkg::*;

    localparam int         SEM_COUNT   = 32;
    localparam int         PROC_COUNT  = 32;
    localparam logic [5:0] LINK_NIL    = 6'd32;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SCRIPT_LEN  = 25;
    localparam int         POOL_KEYS   = 8;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    semaphore_wait_queue_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // model of the descriptor pool and process queues
    logic        wq_busy    [SEM_COUNT];
    logic [31:0] wq_key     [SEM_COUNT];
    logic [5:0]  wq_head    [SEM_COUNT];
    logic [5:0]  wq_tail    [SEM_COUNT];
    logic        pr_blocked [PROC_COUNT];
    logic [4:0]  pr_slot    [PROC_COUNT];
    logic [5:0]  pr_next    [PROC_COUNT];
    logic [5:0]  pr_prev    [PROC_COUNT];

    t_out        pending_results[$];
    t_out        oldest;
    logic [31:0] pool_keys [POOL_KEYS];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          in_idle_pct    = 0;
    int          out_stall_pct  = 0;
    int          hold_cycles    = 0;
    int          phase_count    = 0;
    int          seen_phase     = 0;
    int          hold_left      = 0;

    t_script_row script [SCRIPT_LEN] = '{
        '{'{CMD_HEAD,   32'h0000_0000, 5'd0},  1'b1, '{STS_NOTFOUND, 5'd0}},
        '{'{CMD_REMOVE, 32'hFFFF_FFFF, 5'd0},  1'b1, '{STS_NOTFOUND, 5'd0}},
        '{'{CMD_OUT,    32'h0000_0000, 5'd31}, 1'b1, '{STS_NOTFOUND, 5'd0}},
        '{'{CMD_INSERT, 32'h0000_0000, 5'd0},  1'b1, '{STS_OK,       5'd0}},
        '{'{CMD_INSERT, 32'hFFFF_FFFF, 5'd31}, 1'b1, '{STS_OK,       5'd0}},
        '{'{CMD_INSERT, 32'h0000_0000, 5'd0},  1'b1, '{STS_BLOCKED,  5'd0}},
        '{'{CMD_INSERT, 32'hFFFF_FFFF, 5'd0},  1'b1, '{STS_BLOCKED,  5'd0}},
        '{'{CMD_INSERT, 32'h0000_0000, 5'd5},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_HEAD,   32'h0000_0000, 5'd0},  1'b1, '{STS_OK,       5'd0}},
        '{'{CMD_REMOVE, 32'h0000_0000, 5'd0},  1'b1, '{STS_OK,       5'd0}},
        '{'{CMD_HEAD,   32'h0000_0000, 5'd0},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_OUT,    32'h0000_0000, 5'd5},  1'b1, '{STS_OK,       5'd5}},
        '{'{CMD_HEAD,   32'h0000_0000, 5'd0},  1'b1, '{STS_NOTFOUND, 5'd0}},
        '{'{CMD_INSERT, 32'hFFFF_FFFF, 5'd1},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_INSERT, 32'hFFFF_FFFF, 5'd2},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_OUT,    32'h0000_0000, 5'd1},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_REMOVE, 32'hFFFF_FFFF, 5'd0},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_HEAD,   32'hFFFF_FFFF, 5'd0},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_INSERT, 32'h5555_5555, 5'd10}, 1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_INSERT, 32'hAAAA_AAAA, 5'd21}, 1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_OUT,    32'h0000_0000, 5'd2},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_REMOVE, 32'h5555_5555, 5'd0},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_REMOVE, 32'hAAAA_AAAA, 5'd0},  1'b0, '{STS_OK,       5'd0}},
        '{'{CMD_OUT,    32'h0000_0000, 5'd31}, 1'b1, '{STS_NOTFOUND, 5'd0}},
        '{'{CMD_INSERT, 32'h0000_0000, 5'd31}, 1'b1, '{STS_OK,       5'd0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_queue_model();
        for (int s = 0; s < SEM_COUNT; s++) begin
            wq_busy[s] = 1'b0;
            wq_key[s]  = '0;
            wq_head[s] = LINK_NIL;
            wq_tail[s] = LINK_NIL;
        end
        for (int p = 0; p < PROC_COUNT; p++) begin
            pr_blocked[p] = 1'b0;
            pr_slot[p]    = '0;
            pr_next[p]    = LINK_NIL;
            pr_prev[p]    = LINK_NIL;
        end
    endfunction

    function automatic int find_desc(logic [31:0] key);
        for (int s = 0; s < SEM_COUNT; s++)
            if (wq_busy[s] && wq_key[s] == key) return s;
        return SEM_COUNT;
    endfunction

    function automatic int find_free_desc();
        for (int s = 0; s < SEM_COUNT; s++)
            if (!wq_busy[s]) return s;
        return SEM_COUNT;
    endfunction

    function automatic void unlink_waiter(logic [4:0] p);
        logic [4:0] s;
        logic [5:0] prv;
        logic [5:0] nxt;
        s   = pr_slot[p];
        prv = pr_prev[p];
        nxt = pr_next[p];
        pr_blocked[p] = 1'b0;
        pr_next[p]    = LINK_NIL;
        pr_prev[p]    = LINK_NIL;
        if (prv != LINK_NIL) pr_next[prv[4:0]] = nxt;
        else wq_head[s] = nxt;
        if (nxt != LINK_NIL) pr_prev[nxt[4:0]] = prv;
        else wq_tail[s] = prv;
        if (wq_head[s] == LINK_NIL) wq_busy[s] = 1'b0;
    endfunction

    function automatic t_out apply_command(t_in c);
        t_out       r;
        int         s;
        logic [5:0] h;
        r.status      = STS_OK;
        r.result_proc = '0;
        case (c.cmd)
            CMD_INSERT: begin
                if (pr_blocked[c.proc_id]) begin
                    r.status = STS_BLOCKED;
                end else begin
                    s = find_desc(c.sem_key);
                    if (s == SEM_COUNT) begin
                        s = find_free_desc();
                        if (s < SEM_COUNT) begin
                            wq_busy[s] = 1'b1;
                            wq_key[s]  = c.sem_key;
                            wq_head[s] = LINK_NIL;
                            wq_tail[s] = LINK_NIL;
                        end
                    end
                    if (s == SEM_COUNT) begin
                        r.status = STS_NO_FREE;
                    end else begin
                        h = wq_tail[s];
                        pr_blocked[c.proc_id] = 1'b1;
                        pr_slot[c.proc_id]    = s[4:0];
                        pr_next[c.proc_id]    = LINK_NIL;
                        pr_prev[c.proc_id]    = h;
                        if (h != LINK_NIL) pr_next[h[4:0]] = {1'b0, c.proc_id};
                        else wq_head[s] = {1'b0, c.proc_id};
                        wq_tail[s] = {1'b0, c.proc_id};
                    end
                end
            end
            CMD_HEAD, CMD_REMOVE: begin
                s = find_desc(c.sem_key);
                h = (s < SEM_COUNT) ? wq_head[s] : LINK_NIL;
                if (h == LINK_NIL) begin
                    r.status = STS_NOTFOUND;
                end else begin
                    r.result_proc = h[4:0];
                    if (c.cmd == CMD_REMOVE) unlink_waiter(h[4:0]);
                end
            end
            default: begin
                if (!pr_blocked[c.proc_id]) begin
                    r.status = STS_NOTFOUND;
                end else begin
                    r.result_proc = c.proc_id;
                    unlink_waiter(c.proc_id);
                end
            end
        endcase
        return r;
    endfunction

    // mostly well-formed traffic: keys that are live or recently used,
    // processes that are blocked for out and free for insert
    function automatic t_in pick_command();
        t_in         c;
        int          roll;
        logic [31:0] live_keys[$];
        logic [4:0]  blocked_procs[$];
        logic [4:0]  free_procs[$];
        for (int s = 0; s < SEM_COUNT; s++)
            if (wq_busy[s]) live_keys.push_back(wq_key[s]);
        for (int p = 0; p < PROC_COUNT; p++)
            if (pr_blocked[p]) blocked_procs.push_back(p[4:0]);
            else free_procs.push_back(p[4:0]);
        if ($urandom_range(24) == 0)
            pool_keys[$urandom_range(POOL_KEYS - 1)] = $urandom();

        roll = $urandom_range(99);
        if (roll < 35)      c.cmd = CMD_INSERT;
        else if (roll < 65) c.cmd = CMD_REMOVE;
        else if (roll < 82) c.cmd = CMD_OUT;
        else                c.cmd = CMD_HEAD;

        roll = $urandom_range(99);
        if (c.cmd != CMD_INSERT && roll < 60 && live_keys.size() > 0)
            c.sem_key = live_keys[$urandom_range(live_keys.size() - 1)];
        else if (roll < 85)
            c.sem_key = pool_keys[$urandom_range(POOL_KEYS - 1)];
        else
            c.sem_key = $urandom();

        roll = $urandom_range(99);
        if (c.cmd == CMD_OUT && roll < 75 && blocked_procs.size() > 0)
            c.proc_id = blocked_procs[$urandom_range(blocked_procs.size() - 1)];
        else if (c.cmd == CMD_INSERT && roll < 75 && free_procs.size() > 0)
            c.proc_id = free_procs[$urandom_range(free_procs.size() - 1)];
        else
            c.proc_id = 5'($urandom_range(PROC_COUNT - 1));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_command(input t_in c, input logic typed, input t_out want);
        t_out predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = c;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_command(c);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic run_random_phase(input int n_items, input int idle_pct,
                                    input int stall_pct, input int hold);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        hold_cycles   = hold;
        phase_count++;
        for (int n = 0; n < n_items; n++)
            send_command(pick_command(), 1'b0, '0);
        drain_results();
    endtask

    // receiver: an optional long hold at the start of a phase, then random stalls
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (seen_phase != phase_count) begin
                seen_phase = phase_count;
                hold_left  = hold_cycles;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, status",
                                int'(o_out_data.status), 0);
            end else begin
                oldest = pending_results.pop_front();
                if (o_out_data.status !== oldest.status)
                    report_mismatch("status", int'(o_out_data.status),
                                    int'(oldest.status));
                if (o_out_data.result_proc !== oldest.result_proc)
                    report_mismatch("result_proc", int'(o_out_data.result_proc),
                                    int'(oldest.result_proc));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d transactions outstanding", pending_results.size());
            $display("tb_semaphore_wait_queue_table NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        clear_queue_model();
        pool_keys[0] = 32'h0000_0000;
        pool_keys[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < POOL_KEYS; k++) pool_keys[k] = $urandom();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++)
            send_command(script[r].item, script[r].typed, script[r].want);
        drain_results();

        run_random_phase(160, 0, 0, 150);
        run_random_phase(160, 55, 0, 0);
        run_random_phase(160, 0, 55, 0);
        run_random_phase(160, 27, 27, 0);

        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_semaphore_wait_queue_table OK");
        end else begin
            $display("tb_semaphore_wait_queue_table NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/swqt_pkg.sv
rtl/core/swqt_sem_dir.sv
rtl/core/swqt_ctrl.sv
rtl/core/semaphore_wait_queue_table.sv
tb/sv/tb_semaphore_wait_queue_table.sv
